FILE: rtl/core/cltf_pkg.sv
// Package for the closed tour length and fitness block.
// Field widths, iteration counts, controller states and the command/status
// structs shared by the controller, the datapath and the top level.
package cltf_pkg;

   localparam int COORD_W   = 19;
   localparam int ABS_W     = 19;
   localparam int SQ_W      = 2 * ABS_W;
   localparam int RAD_W     = 40;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int REM_W     = ROOT_W + 1;
   localparam int LEN_W     = 40;
   localparam int RANGE_W   = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 2 * LEN_W;

   localparam int ROOT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = LEN_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(1000);
   localparam logic [LEN_W-1:0]   LEN_MAX     = {LEN_W{1'b1}};

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIFF,
      S_SQ_X,
      S_SQ_Y,
      S_ROOT_INIT,
      S_ROOT,
      S_ACC,
      S_RANGE_SQ,
      S_DIV_INIT,
      S_DIV,
      S_FINISH
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TAKE,
      OP_DIFF,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_RANGE,
      OP_ROOT_INIT,
      OP_ROOT_STEP,
      OP_ACC,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      ref_start;
   } dp_cmd_type;

   typedef struct packed {
      logic mid_tour;
      logic last_city;
      logic div_sat;
   } dp_status_type;

endpackage

FILE: rtl/core/cltf_ctrl.sv
// Controller state machine for the closed tour length and fitness block.
// Sequences edge, square root, accumulate and divide steps; owns the result
// valid flag. Depends on cltf_pkg.
module cltf_ctrl import cltf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tlast,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type   state_ff, state_in;
   logic             closing_ff, closing_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         closing_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         closing_ff   <= closing_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      closing_in    = closing_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      cmd.op        = OP_NONE;
      cmd.ref_start = closing_ff;
      req_tready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = OP_TAKE;
               if (!status.mid_tour) begin
                  // first city: only a single-city tour needs an edge
                  closing_in = 1'b1;
                  if (req_tlast) begin
                     state_in = S_DIFF;
                  end
               end else begin
                  closing_in = 1'b0;
                  state_in   = S_DIFF;
               end
            end
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = S_SQ_X;
         end
         S_SQ_X: begin
            cmd.op   = OP_SQ_X;
            state_in = S_SQ_Y;
         end
         S_SQ_Y: begin
            cmd.op   = OP_SQ_Y;
            state_in = S_ROOT_INIT;
         end
         S_ROOT_INIT: begin
            cmd.op   = OP_ROOT_INIT;
            cnt_in   = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.op = OP_ROOT_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            if (closing_ff) begin
               state_in = S_RANGE_SQ;
            end else if (status.last_city) begin
               closing_in = 1'b1;
               state_in   = S_DIFF;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RANGE_SQ: begin
            cmd.op   = OP_SQ_RANGE;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (status.div_sat) begin
               state_in = S_FINISH;
            end else begin
               cmd.op = OP_DIV_STEP;
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = OP_RESULT;
               rsp_valid_in = 1'b1;
               closing_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/core/cltf_dp.sv
// Datapath for the closed tour length and fitness block: city registers,
// shared squarer, bit-pair square root, saturating sum, restoring divider
// and result register. Driven by cltf_ctrl commands; depends on cltf_pkg.
module cltf_dp import cltf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [RANGE_W-1:0]        csr_wr_data,
   input  logic signed [COORD_W-1:0] city_x,
   input  logic signed [COORD_W-1:0] city_y,
   input  logic                      last_city,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   output logic [LEN_W-1:0]          tour_length,
   output logic [LEN_W-1:0]          tour_fitness,
   output logic                      zero_length
);

   logic [RANGE_W-1:0]        range_ff;
   logic                      mid_ff;
   logic signed [COORD_W-1:0] cur_x_ff, cur_y_ff;
   logic signed [COORD_W-1:0] start_x_ff, start_y_ff;
   logic signed [COORD_W-1:0] prior_x_ff, prior_y_ff;
   logic                      last_ff;
   logic [ABS_W-1:0]          adx_ff, ady_ff;
   logic [SQ_W-1:0]           sqa_ff, sqb_ff;
   logic [RAD_W-1:0]          rad_ff;
   logic [REM_W-1:0]          rrem_ff;
   logic [ROOT_W-1:0]         root_ff;
   logic [LEN_W-1:0]          sum_ff;
   logic [LEN_W-1:0]          drem_ff, dq_ff;
   logic                      dsat_ff;
   logic [LEN_W-1:0]          len_ff, fit_ff;
   logic                      zero_ff;

   logic signed [COORD_W-1:0] ref_x, ref_y;
   logic signed [COORD_W:0]   dx, dy;
   logic [COORD_W:0]          dx_abs, dy_abs;
   logic [ABS_W-1:0]          mul_op;
   logic [SQ_W-1:0]           mul_p;
   logic [REM_W+1:0]          rem_sh;
   logic [REM_W:0]            trial;
   logic                      root_ge;
   logic [REM_W+1:0]          rem_sub;
   logic [LEN_W:0]            acc_sum;
   logic [31:0]               r2;
   logic [LEN_W-1:0]          div_hi;
   logic [LEN_W:0]            drem_sh;
   logic                      div_ge;
   logic [LEN_W:0]            drem_sub;

   assign ref_x  = cmd.ref_start ? start_x_ff : prior_x_ff;
   assign ref_y  = cmd.ref_start ? start_y_ff : prior_y_ff;
   assign dx     = {cur_x_ff[COORD_W-1], cur_x_ff} - {ref_x[COORD_W-1], ref_x};
   assign dy     = {cur_y_ff[COORD_W-1], cur_y_ff} - {ref_y[COORD_W-1], ref_y};
   assign dx_abs = dx[COORD_W] ? -dx : dx;
   assign dy_abs = dy[COORD_W] ? -dy : dy;

   always_comb begin
      case (cmd.op)
         OP_SQ_Y:     mul_op = ady_ff;
         OP_SQ_RANGE: mul_op = ABS_W'(range_ff);
         default:     mul_op = adx_ff;
      endcase
   end
   assign mul_p = mul_op * mul_op;

   // one result bit per cycle from the top bit pair of the radicand
   assign rem_sh  = {rrem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign root_ge = rem_sh >= {1'b0, trial};
   assign rem_sub = rem_sh - {1'b0, trial};

   assign acc_sum = {1'b0, sum_ff} + (LEN_W+1)'(root_ff);

   // numerator is r^2 << 32; the quotient overflows 40 bits when the numerator's top
   // 24 bits are not below the length
   assign r2       = sqa_ff[31:0];
   assign div_hi   = LEN_W'(r2[31:8]);
   assign drem_sh  = {drem_ff, dq_ff[LEN_W-1]};
   assign div_ge   = drem_sh >= {1'b0, sum_ff};
   assign drem_sub = drem_sh - {1'b0, sum_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= RANGE_RESET;
         mid_ff   <= 1'b0;
         sum_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            range_ff <= csr_wr_data;
         end
         case (cmd.op)
            OP_TAKE: begin
               if (!mid_ff) begin
                  mid_ff <= 1'b1;
                  sum_ff <= '0;
               end
            end
            OP_ACC: begin
               sum_ff <= acc_sum[LEN_W] ? LEN_MAX : acc_sum[LEN_W-1:0];
            end
            OP_RESULT: begin
               mid_ff <= 1'b0;
               sum_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_TAKE: begin
            cur_x_ff <= city_x;
            cur_y_ff <= city_y;
            last_ff  <= last_city;
            if (!mid_ff) begin
               start_x_ff <= city_x;
               start_y_ff <= city_y;
               prior_x_ff <= city_x;
               prior_y_ff <= city_y;
            end
         end
         OP_DIFF: begin
            adx_ff     <= dx_abs[ABS_W-1:0];
            ady_ff     <= dy_abs[ABS_W-1:0];
            prior_x_ff <= cur_x_ff;
            prior_y_ff <= cur_y_ff;
         end
         OP_SQ_X, OP_SQ_RANGE: begin
            sqa_ff <= mul_p;
         end
         OP_SQ_Y: begin
            sqb_ff <= mul_p;
         end
         OP_ROOT_INIT: begin
            rad_ff  <= RAD_W'(sqa_ff) + RAD_W'(sqb_ff);
            rrem_ff <= '0;
            root_ff <= '0;
         end
         OP_ROOT_STEP: begin
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            rrem_ff <= root_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], root_ge};
         end
         OP_DIV_INIT: begin
            drem_ff <= div_hi;
            dq_ff   <= {r2[7:0], 32'd0};
            dsat_ff <= div_hi >= sum_ff;
         end
         OP_DIV_STEP: begin
            drem_ff <= div_ge ? drem_sub[LEN_W-1:0] : drem_sh[LEN_W-1:0];
            dq_ff   <= {dq_ff[LEN_W-2:0], div_ge};
         end
         OP_RESULT: begin
            len_ff  <= sum_ff;
            fit_ff  <= dsat_ff ? LEN_MAX : dq_ff;
            zero_ff <= sum_ff == '0;
         end
         default: begin
         end
      endcase
   end

   assign status.mid_tour  = mid_ff;
   assign status.last_city = last_ff;
   assign status.div_sat   = dsat_ff;
   assign tour_length      = len_ff;
   assign tour_fitness     = fit_ff;
   assign zero_length      = zero_ff;

endmodule

FILE: rtl/core/closed_tour_length_fitness.sv
// Closed tour length and fitness. A city that closes no edge is only taken;
// any other city runs a difference, x and y squares, a root init, the bit-pair
// square root steps and an accumulate; the closing edge, a range square and a
// restoring divide end the tour, then it waits for the result register to drain.
// Synchronous active-high reset: range_km returns to 1000, tour state clears.
// Depends on cltf_pkg, cltf_ctrl and cltf_dp.
module closed_tour_length_fitness import cltf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [RANGE_W-1:0]    csr_wr_data,   // range_km
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,     // city_x[18:0], city_y[37:19], zero pad
   input  logic                  req_tlast,     // last_city
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,     // tour_length[39:0], tour_fitness[79:40]
   output logic                  rsp_tuser      // zero_length
);

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [LEN_W-1:0]    tour_length, tour_fitness;

   cltf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cltf_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .city_x       (req_tdata[COORD_W-1:0]),
      .city_y       (req_tdata[2*COORD_W-1:COORD_W]),
      .last_city    (req_tlast),
      .cmd          (cmd),
      .status       (status),
      .tour_length  (tour_length),
      .tour_fitness (tour_fitness),
      .zero_length  (rsp_tuser)
   );

   assign rsp_tdata = {tour_fitness, tour_length};

endmodule

FILE: rtl/core/cltf_checker.sv
// Port-level checks for the closed tour length and fitness block, bound to
// the top level. Depends on cltf_pkg.
module cltf_checker import cltf_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[RSP_DATA_W-1:LEN_W] == LEN_MAX)
      else $error("zero length without saturated fitness");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[LEN_W-1:0] == '0) == rsp_tuser))
      else $error("zero length flag disagrees with length");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> !$rose(rsp_tvalid))
      else $error("result item right after a non-final city");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind closed_tour_length_fitness cltf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
